/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the allocator RTL.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define BPA_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("allocator check failed");

// Next-cycle implication.
`define BPA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("allocator check failed");

`endif

/* hw/rtl/bpa_pkg.sv */
// Shared constants, status codes and controller/datapath structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bpa_pkg;
	localparam int PAGE_CAP       = 1024;
	localparam int PAGE_SIZE_LOG2 = 16;
	localparam int WORD_BITS      = 64;
	localparam int MAP_WORDS      = PAGE_CAP / WORD_BITS;
	localparam int WSEL_W         = $clog2(MAP_WORDS);
	localparam int PAGE_W         = $clog2(PAGE_CAP);
	localparam int PIDX_W         = PAGE_W + 2;
	localparam int ADDR_W         = 48;
	localparam int LEN_W          = 27;
	localparam int CNT_W          = 11;
	localparam int GRP_W          = PAGE_W - 3;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_ZERO    = 3'd1;
	localparam logic [2:0] ST_NOSPACE = 3'd2;
	localparam logic [2:0] ST_RANGE   = 3'd3;
	localparam logic [2:0] ST_NOTUSED = 3'd4;
	localparam logic [2:0] ST_ALIGN   = 3'd5;

	localparam logic CFG_HEAP_BASE  = 1'b0;
	localparam logic CFG_PAGE_COUNT = 1'b1;

	typedef struct packed {
		logic       load;
		logic       prep;
		logic       range_go;
		logic       scan_step;
		logic       verify;
		logic       mark;
		logic       clear;
		logic       finish;
		logic [2:0] fin_status;
	} cmd_t;

	typedef struct packed {
		logic is_free;
		logic bad_align;
		logic zero_len;
		logic out_range;
		logic n_zero;
		logic found;
		logic scan_end;
		logic word_last;
		logic verify_fail;
	} stat_t;

	// Pages of word w that fall in [lo, hi].
	function automatic logic [WORD_BITS-1:0] word_mask(input logic [WSEL_W-1:0] w,
			input logic [PIDX_W-1:0] lo, input logic [PIDX_W-1:0] hi);
		logic [WORD_BITS-1:0] m;
		logic [PIDX_W-1:0]    idx;
		m = '0;
		for (int b = 0; b < WORD_BITS; b++) begin
			idx = {2'b00, w, 6'(b)};
			m[b] = (idx >= lo) && (idx <= hi);
		end
		return m;
	endfunction
endpackage
`default_nettype wire

/* hw/rtl/bpa_ctrl.sv */
// Allocator sequencer: one-hot state machine issuing datapath commands.
// Depends on bpa_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module bpa_ctrl import bpa_pkg::*; (
	input  wire   clk,
	input  wire   arst_n,
	input  wire   start,
	output logic  busy,
	input  stat_t st,
	output cmd_t  cmd
);
	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_PREP   = 8'b0000_0010,
		S_RANGE  = 8'b0000_0100,
		S_SCAN   = 8'b0000_1000,
		S_MARK   = 8'b0001_0000,
		S_VERIFY = 8'b0010_0000,
		S_CLEAR  = 8'b0100_0000,
		S_SPARE  = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d = S_PREP;
				end
			end
			S_PREP: begin
				cmd.prep = 1'b1;
				priority if (st.is_free) begin
					state_d = S_RANGE;
				end else if (st.bad_align) begin
					cmd.finish = 1'b1;
					cmd.fin_status = ST_ALIGN;
					state_d = S_IDLE;
				end else if (st.zero_len) begin
					cmd.finish = 1'b1;
					cmd.fin_status = ST_ZERO;
					state_d = S_IDLE;
				end else begin
					state_d = S_SCAN;
				end
			end
			S_RANGE: begin
				cmd.range_go = 1'b1;
				priority if (st.out_range) begin
					cmd.finish = 1'b1;
					cmd.fin_status = ST_RANGE;
					state_d = S_IDLE;
				end else if (st.n_zero) begin
					cmd.finish = 1'b1;
					cmd.fin_status = ST_OK;
					state_d = S_IDLE;
				end else begin
					state_d = S_VERIFY;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				priority if (st.found) begin
					state_d = S_MARK;
				end else if (st.scan_end) begin
					cmd.finish = 1'b1;
					cmd.fin_status = ST_NOSPACE;
					state_d = S_IDLE;
				end
			end
			S_MARK: begin
				cmd.mark = 1'b1;
				if (st.word_last) begin
					cmd.finish = 1'b1;
					cmd.fin_status = ST_OK;
					state_d = S_IDLE;
				end
			end
			S_VERIFY: begin
				cmd.verify = 1'b1;
				priority if (st.verify_fail) begin
					cmd.finish = 1'b1;
					cmd.fin_status = ST_NOTUSED;
					state_d = S_IDLE;
				end else if (st.word_last) begin
					state_d = S_CLEAR;
				end
			end
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (st.word_last) begin
					cmd.finish = 1'b1;
					cmd.fin_status = ST_OK;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

	`BPA_ASSERT_NEXT(a_start_goes_prep, start && (state_q == S_IDLE), state_q == S_PREP)
endmodule
`default_nettype wire

/* hw/rtl/bpa_dp.sv */
// Allocator datapath: config registers, page bitmap, scan and word sweep logic.
// Depends on bpa_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module bpa_dp import bpa_pkg::*; (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                cfg_we,
	input  wire                cfg_index,
	input  wire  [ADDR_W-1:0]  cfg_data,
	input  wire                kind,
	input  wire  [LEN_W-1:0]   byte_length,
	input  wire  [CNT_W-1:0]   align_pages,
	input  wire  [ADDR_W-1:0]  address,
	input  cmd_t               cmd,
	output stat_t              st,
	output logic               done,
	output logic [2:0]         status,
	output logic [ADDR_W-1:0]  result_address,
	output logic [PAGE_W-1:0]  first_page
);
	logic [ADDR_W-1:0]    heap_base_q;
	logic [CNT_W-1:0]     page_count_q;
	logic [WORD_BITS-1:0] map_q [MAP_WORDS];

	logic                 kind_q;
	logic [LEN_W-1:0]     len_q;
	logic [ADDR_W-1:0]    addr_q;
	logic [CNT_W-2:0]     am_q;
	logic                 bad_align_q;
	logic [PIDX_W-1:0]    need_q;
	logic [ADDR_W:0]      sum_q;
	logic [ADDR_W:0]      limit_q;
	logic [ADDR_W-1:0]    off_q;
	logic                 below_q;
	logic [PIDX_W-1:0]    cand_q;
	logic [GRP_W-1:0]     grp_q;
	logic [PIDX_W-1:0]    lo_q;
	logic [PIDX_W-1:0]    hi_q;
	logic [WSEL_W-1:0]    w_q;

	logic                 done_q;
	logic [2:0]           status_q;
	logic [ADDR_W-1:0]    res_addr_q;
	logic [PAGE_W-1:0]    first_page_q;

	logic [CNT_W-1:0]     usable;
	logic [CNT_W-2:0]     am_in;
	logic [PIDX_W:0]      need_in;
	logic [CNT_W-1:0]     start_pg;
	logic [WORD_BITS-1:0] mask;
	logic [7:0]           grp_bits;
	logic [PIDX_W-1:0]    scan_cand;
	logic                 scan_hit;
	logic [PIDX_W-1:0]    hit_cand;
	logic [PIDX_W-1:0]    hit_end;
	logic [GRP_W:0]       grp_next;

	assign usable = (page_count_q > CNT_W'(PAGE_CAP)) ? CNT_W'(PAGE_CAP) : page_count_q;
	assign am_in  = (align_pages == '0) ? '0 : 10'(align_pages - 11'd1);
	assign need_in = 13'((({1'b0, byte_length} + 28'((1 << PAGE_SIZE_LOG2) - 1))
		>> PAGE_SIZE_LOG2));
	assign start_pg = off_q[PAGE_SIZE_LOG2 +: CNT_W];
	assign mask = word_mask(w_q, lo_q, hi_q);
	assign grp_bits = map_q[grp_q[GRP_W-1 -: WSEL_W]][{grp_q[2:0], 3'b000} +: 8];
	assign grp_next = {1'b0, grp_q} + 8'd1;

	function automatic logic [PIDX_W-1:0] align_up(input logic [PIDX_W-1:0] x,
			input logic [CNT_W-2:0] am);
		return (x + {2'b00, am}) & ~{2'b00, am};
	endfunction

	// First-fit walk over eight pages of the current group.
	always_comb begin
		logic [PAGE_W-1:0] p;
		scan_cand = cand_q;
		scan_hit = 1'b0;
		hit_cand = '0;
		hit_end = '0;
		for (int j = 0; j < 8; j++) begin
			p = {grp_q, 3'(j)};
			if (!scan_hit && ({1'b0, p} < usable)) begin
				if (grp_bits[j]) begin
					scan_cand = align_up({2'b00, p} + 12'd1, am_q);
				end else if (({2'b00, p} >= scan_cand) &&
						(({3'b000, p} + 13'd1) == ({1'b0, scan_cand} + {1'b0, need_q}))) begin
					scan_hit = 1'b1;
					hit_cand = scan_cand;
					hit_end = {2'b00, p};
				end
			end
		end
	end

	always_comb begin
		st = '0;
		st.is_free     = kind_q;
		st.bad_align   = bad_align_q;
		st.zero_len    = (len_q == '0);
		st.out_range   = below_q || (sum_q > limit_q);
		st.n_zero      = (need_q == '0);
		st.found       = scan_hit;
		st.scan_end    = ({grp_next, 3'b000} >= {1'b0, usable});
		st.word_last   = (w_q == hi_q[PAGE_W-1 -: WSEL_W]);
		st.verify_fail = ((map_q[w_q] & mask) != mask);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_base_q  <= '0;
			page_count_q <= CNT_W'(PAGE_CAP);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_HEAP_BASE:  heap_base_q <= cfg_data;
				CFG_PAGE_COUNT: page_count_q <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAP_WORDS; i++) begin
				map_q[i] <= '0;
			end
		end else if (cmd.mark) begin
			map_q[w_q] <= map_q[w_q] | mask;
		end else if (cmd.clear) begin
			map_q[w_q] <= map_q[w_q] & ~mask;
		end
	end

	// Request payload and working registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q      <= kind;
			len_q       <= byte_length;
			addr_q      <= address;
			am_q        <= am_in;
			bad_align_q <= (align_pages != '0) &&
				((align_pages & (align_pages - 11'd1)) != '0);
			need_q      <= need_in[PIDX_W-1:0];
		end
		if (cmd.prep) begin
			sum_q   <= {1'b0, addr_q} + {{(ADDR_W-LEN_W+1){1'b0}}, len_q};
			limit_q <= {1'b0, heap_base_q} +
				{{(ADDR_W-CNT_W-PAGE_SIZE_LOG2+1){1'b0}}, usable, {PAGE_SIZE_LOG2{1'b0}}};
			off_q   <= addr_q - heap_base_q;
			below_q <= (addr_q < heap_base_q);
			cand_q  <= '0;
			grp_q   <= '0;
		end
		if (cmd.range_go) begin
			lo_q <= {1'b0, start_pg};
			hi_q <= {1'b0, start_pg} + need_q - 12'd1;
			w_q  <= start_pg[PAGE_W-1 -: WSEL_W];
		end
		if (cmd.scan_step) begin
			if (scan_hit) begin
				lo_q <= hit_cand;
				hi_q <= hit_end;
				w_q  <= hit_cand[PAGE_W-1 -: WSEL_W];
			end else begin
				cand_q <= scan_cand;
				grp_q  <= grp_next[GRP_W-1:0];
			end
		end
		if (cmd.verify) begin
			// rewind to the first word for the clear sweep
			w_q <= st.word_last ? lo_q[PAGE_W-1 -: WSEL_W] : w_q + 1'b1;
		end
		if (cmd.mark || cmd.clear) begin
			w_q <= w_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			status_q <= cmd.fin_status;
			if (!kind_q && (cmd.fin_status == ST_OK)) begin
				res_addr_q <= heap_base_q +
					{{(ADDR_W-PAGE_W-PAGE_SIZE_LOG2){1'b0}}, lo_q[PAGE_W-1:0],
					{PAGE_SIZE_LOG2{1'b0}}};
				first_page_q <= lo_q[PAGE_W-1:0];
			end else begin
				res_addr_q <= '0;
				first_page_q <= (kind_q && (cmd.fin_status != ST_RANGE)) ?
					start_pg[PAGE_W-1:0] : '0;
			end
		end
	end

	assign done = done_q;
	assign status = status_q;
	assign result_address = res_addr_q;
	assign first_page = first_page_q;

	`BPA_ASSERT_NEXT(a_done_single, done_q, !done_q)
	`BPA_ASSERT_IMPL(a_fail_zero_addr, done_q && (status_q != ST_OK), res_addr_q == '0)
endmodule
`default_nettype wire

/* hw/rtl/bitmap_page_allocator.sv */
// Bitmap first-fit page allocator top level: sequencer plus datapath.
// Depends on bpa_pkg, bpa_ctrl and bpa_dp.
//
//   channel   handshake              payload
//   request   start, accepted !busy  kind, byte_length, align_pages, address
//   result    done, one-cycle strobe status, result_address, first_page
//   config    cfg_we                 cfg_index, cfg_data
//
// Allocate: setup, then a first-fit scan over groups of 8 pages up to the page
// count, then a sweep marking each bitmap word of the run.
// Free: setup and range check, then a check sweep and a clear sweep over the words touched.
// The result strobe rises at the same edge where busy drops; results cannot stall.
// arst_n clears the bitmap to all free and loads the register reset values.
`timescale 1ns / 1ps
`default_nettype none
module bitmap_page_allocator import bpa_pkg::*; (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                cfg_we,
	input  wire                cfg_index,
	input  wire  [ADDR_W-1:0]  cfg_data,
	input  wire                start,
	output logic               busy,
	input  wire                kind,
	input  wire  [LEN_W-1:0]   byte_length,
	input  wire  [CNT_W-1:0]   align_pages,
	input  wire  [ADDR_W-1:0]  address,
	output logic               done,
	output logic [2:0]         status,
	output logic [ADDR_W-1:0]  result_address,
	output logic [PAGE_W-1:0]  first_page
);
	cmd_t  cmd;
	stat_t st;

	bpa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.st     (st),
		.cmd    (cmd)
	);

	bpa_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.kind           (kind),
		.byte_length    (byte_length),
		.align_pages    (align_pages),
		.address        (address),
		.cmd            (cmd),
		.st             (st),
		.done           (done),
		.status         (status),
		.result_address (result_address),
		.first_page     (first_page)
	);
endmodule
`default_nettype wire
